// ----- design/motor_resistance_measure_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the motor resistance measurement unit
// Concurrent property wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef MOTOR_RESISTANCE_MEASURE_UNIT_ASSERT_SVH
`define MOTOR_RESISTANCE_MEASURE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MRM_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("mrm assertion failed");
`define MRM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrm assertion failed");
`define MRM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrm assertion failed");
`else
`define MRM_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define MRM_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define MRM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- design/mrm_pkg.sv -----
// ----------------------------------------------------------------------------
// Motor resistance measurement package
// Types, codes and constants shared by the interfaces and the top level.
// ----------------------------------------------------------------------------
package mrm_pkg;

  localparam int COUNTER_BITS = 20;
  localparam int CMP_BITS = (COUNTER_BITS > 20) ? COUNTER_BITS : 20;
  localparam logic [COUNTER_BITS-1:0] COUNTER_MAX = '1;

  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [2:0] REG_TARGET_CURRENT     = 3'd0;
  localparam logic [2:0] REG_DUTY_LIMIT         = 3'd1;
  localparam logic [2:0] REG_SETTLE_TICKS       = 3'd2;
  localparam logic [2:0] REG_SAMPLES_WANTED     = 3'd3;
  localparam logic [2:0] REG_RESISTANCE_FLOOR   = 3'd4;
  localparam logic [2:0] REG_RESISTANCE_CEILING = 3'd5;
  localparam logic [2:0] REG_TIMEOUT_LIMIT      = 3'd6;

  localparam logic [14:0] RST_TARGET_CURRENT     = 15'd1280;
  localparam logic [14:0] RST_DUTY_LIMIT         = 15'd16384;
  localparam logic [15:0] RST_SETTLE_TICKS       = 16'd500;
  localparam logic [15:0] RST_SAMPLES_WANTED     = 16'd1000;
  localparam logic [14:0] RST_RESISTANCE_FLOOR   = 15'd3;
  localparam logic [14:0] RST_RESISTANCE_CEILING = 15'd2560;
  localparam logic [19:0] RST_TIMEOUT_LIMIT      = 20'd200000;

  localparam logic [14:0] MIN_CURRENT   = 15'd128;
  localparam logic [15:0] DUTY_CENTER   = 16'd32768;
  localparam logic [5:0]  PROGRESS_FULL = 6'd33;
  localparam int          GAIN_SHIFT    = 4;
  localparam int          DUTY_SUM_BITS = 16 + GAIN_SHIFT + 1;

  localparam int MUL_BITS     = 15;
  localparam int MUL_CNT_BITS = $clog2(MUL_BITS + 1);
  localparam logic [MUL_CNT_BITS-1:0] MUL_STEPS = MUL_CNT_BITS'(MUL_BITS);

  localparam int DIV_BITS     = 48;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
  localparam logic [DIV_CNT_BITS-1:0] STEPS_R    = DIV_CNT_BITS'(23);
  localparam logic [DIV_CNT_BITS-1:0] STEPS_MEAN = DIV_CNT_BITS'(32);
  localparam logic [DIV_CNT_BITS-1:0] STEPS_SQ   = DIV_CNT_BITS'(48);
  localparam logic [DIV_CNT_BITS-1:0] STEPS_PROG = DIV_CNT_BITS'(22);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SETTLE,
    MODE_SAMPLE,
    MODE_DONE,
    MODE_FAIL
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK,
    ERR_TIMEOUT,
    ERR_LOW,
    ERR_HIGH
  } err_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_TICK,
    SQ_MUL_V,
    SQ_DIV_R,
    SQ_MUL_SQ,
    SQ_ACC,
    SQ_DIV_MEAN,
    SQ_DIV_SQ,
    SQ_MUL_MEAN,
    SQ_FINISH,
    SQ_DIV_PROG
  } seq_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [14:0]        bus_voltage;
    logic signed [15:0] phase_a_current;
  } tick_item_t;

  typedef struct packed {
    logic [15:0] duty_phase_a;
    logic [15:0] duty_phase_bc;
    logic [2:0]  status;
    logic [1:0]  error_code;
    logic [5:0]  progress;
    logic [14:0] mean_resistance;
    logic [15:0] resistance_variance;
  } result_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [19:0] value;
  } cfg_item_t;

endpackage

// ----- design/mrm_ifs.sv -----
// ----------------------------------------------------------------------------
// Motor resistance measurement channels
// Valid/ready interfaces for the tick, result and configuration channels.
// ----------------------------------------------------------------------------
interface mrm_tick_if;
  import mrm_pkg::*;
  logic       valid;
  logic       ready;
  tick_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrm_result_if;
  import mrm_pkg::*;
  logic         valid;
  logic         ready;
  result_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrm_cfg_if;
  import mrm_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/motor_resistance_measure_unit.sv -----
// ----------------------------------------------------------------------------
// Motor resistance measurement unit
// DC injection phase resistance measurement with a bit-serial datapath.
// A tick that takes no sample runs only the progress division before its result.
// A sampling tick first multiplies, divides and squares; the tick that ends a run
// also divides for mean and variance. A shared 1-bit-per-cycle divider and a shift-add multiplier do this arithmetic.
// One item is in work at a time; the next is taken once the result is registered.
// Synchronous reset loads the register defaults and returns to idle at once.
// ----------------------------------------------------------------------------
module motor_resistance_measure_unit (
  input  logic         clk,
  input  logic         rst,
  mrm_tick_if.sink     tick,
  mrm_result_if.source result,
  mrm_cfg_if.sink      cfg
);
  import mrm_pkg::*;
  `include "motor_resistance_measure_unit_assert.svh"

  logic [14:0] target_current;
  logic [14:0] duty_limit;
  logic [15:0] settle_ticks;
  logic [15:0] samples_wanted;
  logic [14:0] resistance_floor;
  logic [14:0] resistance_ceiling;
  logic [19:0] timeout_limit;

  mode_t                   mode;
  err_t                    fail_reason;
  logic [14:0]             drive_duty;
  logic [COUNTER_BITS-1:0] tick_counter;
  logic [15:0]             valid_samples;
  logic [31:0]             sample_sum;
  logic [47:0]             square_sum;
  logic [14:0]             held_mean;
  logic [15:0]             held_variance;

  seq_t seq;
  seq_t seq_next;

  logic [1:0]  cmd_q;
  logic [14:0] vbus_q;
  logic [14:0] mag_q;
  logic [14:0] mag_in;
  logic        drive_on;
  logic        sample_go;
  logic        finish_go;
  logic [14:0] sample_r;
  logic [14:0] mean_q;
  logic [29:0] sq_quot;

  mode_t                   mode_next;
  err_t                    fail_next;
  logic [14:0]             drive_duty_next;
  logic [COUNTER_BITS-1:0] tick_counter_next;
  logic [15:0]             valid_samples_next;
  logic                    run_clear;
  logic                    drive_on_next;
  logic                    sample_go_next;
  logic                    finish_go_next;

  logic [COUNTER_BITS-1:0]   counter_inc;
  logic signed [15:0]        cur_err;
  logic signed [DUTY_SUM_BITS-1:0] duty_sum;
  logic [14:0]               duty_clamped;
  logic [15:0]               wanted_eff;
  logic [21:0]               prog_num_next;
  logic [21:0]               prog_num_cur;
  logic [31:0]               sum_acc;
  logic [29:0]               var_full;
  logic [21:0]               prog_quot;
  logic [5:0]                prog_sat;
  logic                      slot_free;
  logic                      out_load;

  logic [MUL_CNT_BITS-1:0] mul_cnt;
  logic [MUL_BITS-1:0]     mul_a;
  logic [2*MUL_BITS-1:0]   mul_p;
  logic [MUL_BITS:0]       mul_sum;
  logic                    mul_load;
  logic [MUL_BITS-1:0]     mul_a_in;
  logic [MUL_BITS-1:0]     mul_b_in;
  logic                    mul_idle;

  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [DIV_BITS-1:0]     div_dvd;
  logic [15:0]             div_rem;
  logic [15:0]             div_dsr;
  logic [16:0]             rem_shift;
  logic [16:0]             rem_diff;
  logic                    div_ge;
  logic                    div_load;
  logic [DIV_BITS-1:0]     div_init;
  logic [15:0]             div_dsr_in;
  logic [DIV_CNT_BITS-1:0] div_steps;
  logic                    div_idle;

  assign tick.ready = (seq == SQ_IDLE);
  assign cfg.ready  = 1'b1;
  assign slot_free  = !result.valid || result.ready;

  assign mag_in = tick.data.phase_a_current[15]
                ? ((tick.data.phase_a_current == 16'sh8000) ? 15'h7FFF
                   : 15'(-tick.data.phase_a_current))
                : tick.data.phase_a_current[14:0];

  assign wanted_eff = (samples_wanted == 16'd0) ? 16'd1 : samples_wanted;

  assign counter_inc = (tick_counter == COUNTER_MAX) ? tick_counter
                     : tick_counter + 1'b1;
  assign cur_err  = signed'({1'b0, target_current}) - signed'({1'b0, mag_q});
  assign duty_sum = signed'({cur_err[15], cur_err, {GAIN_SHIFT{1'b0}}})
                  + signed'(DUTY_SUM_BITS'(drive_duty));

  always_comb begin
    if (duty_sum[DUTY_SUM_BITS-1]) begin
      duty_clamped = '0;
    end else if (duty_sum[DUTY_SUM_BITS-2:0] > (DUTY_SUM_BITS-1)'(duty_limit)) begin
      duty_clamped = duty_limit;
    end else begin
      duty_clamped = duty_sum[14:0];
    end
  end

  always_comb begin
    mode_next          = mode;
    fail_next          = fail_reason;
    drive_duty_next    = drive_duty;
    tick_counter_next  = tick_counter;
    valid_samples_next = valid_samples;
    run_clear          = 1'b0;
    drive_on_next      = 1'b0;
    sample_go_next     = 1'b0;
    finish_go_next     = 1'b0;
    case (cmd_q)
      CMD_START: begin
        run_clear          = 1'b1;
        mode_next          = MODE_SETTLE;
        fail_next          = ERR_OK;
        drive_duty_next    = '0;
        tick_counter_next  = '0;
        valid_samples_next = '0;
      end
      CMD_CANCEL: begin
        mode_next = MODE_IDLE;
        fail_next = ERR_OK;
      end
      default: begin
        if (mode == MODE_SETTLE || mode == MODE_SAMPLE) begin
          tick_counter_next = counter_inc;
          if (CMP_BITS'(counter_inc) > CMP_BITS'(timeout_limit)) begin
            mode_next = MODE_FAIL;
            fail_next = ERR_TIMEOUT;
          end else if (CMP_BITS'(counter_inc) < CMP_BITS'(settle_ticks)) begin
            drive_duty_next = duty_clamped;
            mode_next       = MODE_SETTLE;
            drive_on_next   = 1'b1;
          end else begin
            mode_next     = MODE_SAMPLE;
            drive_on_next = 1'b1;
            if (mag_q > MIN_CURRENT) begin
              sample_go_next = 1'b1;
              if (valid_samples != 16'hFFFF) begin
                valid_samples_next = valid_samples + 1'b1;
              end
            end
            finish_go_next = (valid_samples_next >= wanted_eff);
          end
        end
      end
    endcase
  end

  assign prog_num_next = {1'b0, valid_samples_next, 5'b0} + {6'b0, valid_samples_next};
  assign prog_num_cur  = {1'b0, valid_samples, 5'b0} + {6'b0, valid_samples};
  assign sum_acc       = sample_sum + 32'(sample_r);
  assign var_full      = sq_quot - mul_p;
  assign prog_quot     = div_dvd[21:0];
  assign prog_sat      = (prog_quot > 22'(PROGRESS_FULL)) ? PROGRESS_FULL : prog_quot[5:0];

  assign mul_idle = (mul_cnt == '0);
  assign mul_sum  = {1'b0, mul_p[2*MUL_BITS-1:MUL_BITS]}
                  + (mul_p[0] ? {1'b0, mul_a} : '0);

  assign div_idle  = (div_cnt == '0);
  assign rem_shift = {div_rem, div_dvd[DIV_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, div_dsr};
  assign div_ge    = (rem_shift >= {1'b0, div_dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  always_comb begin
    seq_next   = seq;
    mul_load   = 1'b0;
    mul_a_in   = '0;
    mul_b_in   = '0;
    div_load   = 1'b0;
    div_init   = '0;
    div_dsr_in = '0;
    div_steps  = '0;
    out_load   = 1'b0;
    unique case (seq)
      SQ_IDLE: begin
        if (tick.valid) begin
          seq_next = SQ_TICK;
        end
      end
      SQ_TICK: begin
        if (sample_go_next) begin
          seq_next = SQ_MUL_V;
          mul_load = 1'b1;
          mul_a_in = drive_duty;
          mul_b_in = vbus_q;
        end else if (finish_go_next) begin
          seq_next   = SQ_DIV_MEAN;
          div_load   = 1'b1;
          div_init   = {sample_sum, 16'b0};
          div_dsr_in = valid_samples_next;
          div_steps  = STEPS_MEAN;
        end else begin
          seq_next   = SQ_DIV_PROG;
          div_load   = 1'b1;
          div_init   = {prog_num_next, 26'b0};
          div_dsr_in = wanted_eff;
          div_steps  = STEPS_PROG;
        end
      end
      SQ_MUL_V: begin
        if (mul_idle) begin
          seq_next   = SQ_DIV_R;
          div_load   = 1'b1;
          div_init   = {mul_p[29:15], 8'b0, 25'b0};
          div_dsr_in = {mag_q, 1'b0};
          div_steps  = STEPS_R;
        end
      end
      SQ_DIV_R: begin
        if (div_idle) begin
          seq_next = SQ_MUL_SQ;
          mul_load = 1'b1;
          mul_a_in = div_dvd[14:0];
          mul_b_in = div_dvd[14:0];
        end
      end
      SQ_MUL_SQ: begin
        if (mul_idle) begin
          seq_next = SQ_ACC;
        end
      end
      SQ_ACC: begin
        if (finish_go) begin
          seq_next   = SQ_DIV_MEAN;
          div_load   = 1'b1;
          div_init   = {sum_acc, 16'b0};
          div_dsr_in = valid_samples;
          div_steps  = STEPS_MEAN;
        end else begin
          seq_next   = SQ_DIV_PROG;
          div_load   = 1'b1;
          div_init   = {prog_num_cur, 26'b0};
          div_dsr_in = wanted_eff;
          div_steps  = STEPS_PROG;
        end
      end
      SQ_DIV_MEAN: begin
        if (div_idle) begin
          seq_next   = SQ_DIV_SQ;
          div_load   = 1'b1;
          div_init   = square_sum;
          div_dsr_in = valid_samples;
          div_steps  = STEPS_SQ;
        end
      end
      SQ_DIV_SQ: begin
        if (div_idle) begin
          seq_next = SQ_MUL_MEAN;
          mul_load = 1'b1;
          mul_a_in = mean_q;
          mul_b_in = mean_q;
        end
      end
      SQ_MUL_MEAN: begin
        if (mul_idle) begin
          seq_next = SQ_FINISH;
        end
      end
      SQ_FINISH: begin
        seq_next   = SQ_DIV_PROG;
        div_load   = 1'b1;
        div_init   = {prog_num_cur, 26'b0};
        div_dsr_in = wanted_eff;
        div_steps  = STEPS_PROG;
      end
      SQ_DIV_PROG: begin
        if (div_idle && slot_free) begin
          out_load = 1'b1;
          seq_next = SQ_IDLE;
        end
      end
      default: begin
        seq_next = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_current     <= RST_TARGET_CURRENT;
      duty_limit         <= RST_DUTY_LIMIT;
      settle_ticks       <= RST_SETTLE_TICKS;
      samples_wanted     <= RST_SAMPLES_WANTED;
      resistance_floor   <= RST_RESISTANCE_FLOOR;
      resistance_ceiling <= RST_RESISTANCE_CEILING;
      timeout_limit      <= RST_TIMEOUT_LIMIT;
      mode               <= MODE_IDLE;
      fail_reason        <= ERR_OK;
      drive_duty         <= '0;
      tick_counter       <= '0;
      valid_samples      <= '0;
      sample_sum         <= '0;
      square_sum         <= '0;
      held_mean          <= '0;
      held_variance      <= '0;
      drive_on           <= 1'b0;
      sample_go          <= 1'b0;
      finish_go          <= 1'b0;
      mul_cnt            <= '0;
      div_cnt            <= '0;
      result.valid       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.data.index)
          REG_TARGET_CURRENT:     target_current     <= cfg.data.value[14:0];
          REG_DUTY_LIMIT:         duty_limit         <= cfg.data.value[14:0];
          REG_SETTLE_TICKS:       settle_ticks       <= cfg.data.value[15:0];
          REG_SAMPLES_WANTED:     samples_wanted     <= cfg.data.value[15:0];
          REG_RESISTANCE_FLOOR:   resistance_floor   <= cfg.data.value[14:0];
          REG_RESISTANCE_CEILING: resistance_ceiling <= cfg.data.value[14:0];
          REG_TIMEOUT_LIMIT:      timeout_limit      <= cfg.data.value;
          default: ;
        endcase
      end

      if (seq == SQ_TICK) begin
        mode          <= mode_next;
        fail_reason   <= fail_next;
        drive_duty    <= drive_duty_next;
        tick_counter  <= tick_counter_next;
        valid_samples <= valid_samples_next;
        drive_on      <= drive_on_next;
        sample_go     <= sample_go_next;
        finish_go     <= finish_go_next;
        if (run_clear) begin
          sample_sum    <= '0;
          square_sum    <= '0;
          held_mean     <= '0;
          held_variance <= '0;
        end
      end

      if (seq == SQ_ACC) begin
        sample_sum <= sum_acc;
        square_sum <= square_sum + 48'(mul_p);
      end

      if (seq == SQ_FINISH) begin
        held_mean     <= mean_q;
        held_variance <= var_full[23:8];
        if (mean_q < resistance_floor) begin
          mode        <= MODE_FAIL;
          fail_reason <= ERR_LOW;
        end else if (mean_q > resistance_ceiling) begin
          mode        <= MODE_FAIL;
          fail_reason <= ERR_HIGH;
        end else begin
          mode        <= MODE_DONE;
          fail_reason <= ERR_OK;
        end
      end

      if (mul_load) begin
        mul_cnt <= MUL_STEPS;
      end else if (!mul_idle) begin
        mul_cnt <= mul_cnt - 1'b1;
      end

      if (div_load) begin
        div_cnt <= div_steps;
      end else if (!div_idle) begin
        div_cnt <= div_cnt - 1'b1;
      end

      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seq == SQ_IDLE && tick.valid) begin
      cmd_q  <= tick.data.cmd;
      vbus_q <= tick.data.bus_voltage;
      mag_q  <= mag_in;
    end

    if (seq == SQ_DIV_R && div_idle) begin
      sample_r <= div_dvd[14:0];
    end
    if (seq == SQ_DIV_MEAN && div_idle) begin
      mean_q <= div_dvd[14:0];
    end
    if (seq == SQ_DIV_SQ && div_idle) begin
      sq_quot <= div_dvd[29:0];
    end

    if (mul_load) begin
      mul_a <= mul_a_in;
      mul_p <= {{MUL_BITS{1'b0}}, mul_b_in};
    end else if (!mul_idle) begin
      mul_p <= {mul_sum, mul_p[MUL_BITS-1:1]};
    end

    if (div_load) begin
      div_dvd <= div_init;
      div_rem <= '0;
      div_dsr <= div_dsr_in;
    end else if (!div_idle) begin
      div_dvd <= {div_dvd[DIV_BITS-2:0], div_ge};
      div_rem <= div_ge ? rem_diff[15:0] : rem_shift[15:0];
    end

    if (out_load) begin
      result.data.duty_phase_a        <= drive_on ? {1'b1, drive_duty} : DUTY_CENTER;
      result.data.duty_phase_bc       <= DUTY_CENTER;
      result.data.status              <= mode;
      result.data.error_code          <= fail_reason;
      result.data.progress            <= prog_sat;
      result.data.mean_resistance     <= held_mean;
      result.data.resistance_variance <= held_variance;
    end
  end

  `MRM_ASSERT_ALWAYS(a_units_exclusive, clk, rst, !(!mul_idle && !div_idle))
  `MRM_ASSERT_IMPLY(a_done_is_ok, clk, rst, mode == MODE_DONE, fail_reason == ERR_OK)
  `MRM_ASSERT_IMPLY(a_fail_has_reason, clk, rst, mode == MODE_FAIL, fail_reason != ERR_OK)
  `MRM_ASSERT_NEXT(a_result_loaded, clk, rst, out_load, result.valid)
  `MRM_ASSERT_IMPLY(a_progress_bound, clk, rst, result.valid, result.data.progress <= PROGRESS_FULL)

endmodule
